>>> rtl/stm_pkg.sv
// stm_pkg: shared types and constants for the statistical TDM multiplexer.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
package stm_pkg;

    // Fixed field widths
    localparam int SLOT_W  = 32;   // slot word: eight 4-bit lanes
    localparam int PKT_W   = 4;    // packet number per lane
    localparam int SRC_W   = 3;    // source address
    localparam int CNT_W   = 4;    // per-slot counts (arrivals, departures), up to 8
    localparam int CFG_W   = 4;    // configuration register width
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Register map (index taken from paddr[2])
    localparam logic [0:0] REG_OUTPUT_RATE    = 1'b0;
    localparam logic [0:0] REG_ACTIVE_SOURCES = 1'b1;

    localparam logic [CFG_W-1:0] OUTPUT_RATE_RST    = 4'd1;
    localparam logic [CFG_W-1:0] ACTIVE_SOURCES_RST = 4'd8;

    // One queue entry
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [PKT_W-1:0] pkt;
    } t_entry;

    // One result waiting for the output channel
    typedef struct packed {
        t_entry entry;
        logic   last;
        logic   ovf;
    } t_out_item;

    // Work handed from the merge stage to the queue for one slot
    typedef struct packed {
        logic [CNT_W-1:0] n_arr;   // arrivals to write
        logic [CNT_W-1:0] n_pop;   // departures to send
        logic             ovf;     // sticky drop flag after this slot's arrivals
    } t_slot_job;

endpackage

>>> rtl/stm_if.sv
// Valid/ready channel interfaces for slot requests and result requests.
// Depends on stm_pkg for field widths.
interface stm_in_if;
    logic                       valid;
    logic                       ready;
    logic [stm_pkg::SLOT_W-1:0] slot_packets;

    modport source (output valid, output slot_packets, input ready);
    modport sink   (input valid, input slot_packets, output ready);
endinterface

interface stm_out_if;
    logic                      valid;
    logic                      ready;
    logic [stm_pkg::SRC_W-1:0] source_address;
    logic [stm_pkg::PKT_W-1:0] packet_number;
    logic                      last_of_slot;
    logic                      overflow_seen;

    modport source (output valid, output source_address, output packet_number,
                    output last_of_slot, output overflow_seen, input ready);
    modport sink   (input valid, input source_address, input packet_number,
                    input last_of_slot, input overflow_seen, output ready);
endinterface

>>> rtl/statistical_tdm_multiplexer.sv
// statistical_tdm_multiplexer: top level with register port, source lanes,
// merge stage and packet queue. Depends on stm_pkg, stm_if, stm_lane,
// stm_merge, stm_queue.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------
//  i_in     | in  | valid / ready    | slot_packets[31:0]
//  o_out    | out | valid / ready    | source_address, packet_number, last_of_slot,
//           |     |                  | overflow_seen
//  apb      | in  | psel/penable     | paddr[2:0], pwdata, prdata (output_rate @0,
//           |     |                  | active_sources @4)
//
// A slot request keeps A arrivals and sends D departures; a departure that waits
// for an arrival of its own slot is read only once that arrival is written. The
// queue memory has one write and one read port, each doing one entry per cycle
// unless the queue is full (write) or empty or the output buffer full (read);
// writes and reads overlap and the next slot is taken on the last step of both.
// From an empty queue a result is written, read into the read register, then
// shown from the output buffer. Reset is synchronous, active low; the queue memory
// needs no clearing. A stalled output holds the reader, and so the next slot.
module statistical_tdm_multiplexer #(
    parameter int NUM_SOURCES = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_RATE    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    stm_in_if.sink                      i_in,
    stm_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stm_pkg::APB_AW-1:0]  paddr,
    input  logic [stm_pkg::APB_DW-1:0]  pwdata,
    output logic [stm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [stm_pkg::CFG_W-1:0] r_output_rate;
    logic [stm_pkg::CFG_W-1:0] r_active_sources;

    logic                      load;
    logic                      load_ready;
    logic [NUM_SOURCES-1:0]    lane_valid;
    stm_pkg::t_entry           lane_entry [NUM_SOURCES];
    stm_pkg::t_entry           list       [NUM_SOURCES];
    stm_pkg::t_slot_job        job;

    // Register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_rate    <= stm_pkg::OUTPUT_RATE_RST;
            r_active_sources <= stm_pkg::ACTIVE_SOURCES_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                stm_pkg::REG_OUTPUT_RATE:    r_output_rate    <= pwdata[stm_pkg::CFG_W-1:0];
                stm_pkg::REG_ACTIVE_SOURCES: r_active_sources <= pwdata[stm_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            stm_pkg::REG_OUTPUT_RATE:    prdata = stm_pkg::APB_DW'(r_output_rate);
            stm_pkg::REG_ACTIVE_SOURCES: prdata = stm_pkg::APB_DW'(r_active_sources);
        endcase
    end

    // Slot request handshake
    assign i_in.ready = load_ready;
    assign load       = i_in.valid && load_ready;

    // One lane per source
    for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_lane
        stm_lane #(
            .LANE (s)
        ) u_lane (
            .i_slot           (i_in.slot_packets),
            .i_active_sources (r_active_sources),
            .o_valid          (lane_valid[s]),
            .o_entry          (lane_entry[s])
        );
    end

    // Merge lanes and book the slot
    stm_merge #(
        .NUM_SOURCES (NUM_SOURCES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_RATE    (MAX_RATE)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_valid       (lane_valid),
        .i_entry       (lane_entry),
        .i_output_rate (r_output_rate),
        .o_list        (list),
        .o_job         (job)
    );

    // Packet queue and result channel
    stm_queue #(
        .NUM_SOURCES (NUM_SOURCES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_list       (list),
        .i_job        (job),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

endmodule

>>> rtl/stm_lane.sv
// stm_lane: qualifies one source lane of a slot word.
// Depends on stm_pkg for the entry type and widths.
module stm_lane #(
    parameter int LANE = 0
) (
    input  logic [stm_pkg::SLOT_W-1:0] i_slot,
    input  logic [stm_pkg::CFG_W-1:0]  i_active_sources,
    output logic                       o_valid,
    output stm_pkg::t_entry            o_entry
);

    logic [stm_pkg::PKT_W-1:0] pkt;

    // Extract this source's nibble
    assign pkt = i_slot[stm_pkg::PKT_W*LANE +: stm_pkg::PKT_W];

    // Lane counts only if the source is enabled and not idle
    assign o_valid = (stm_pkg::CFG_W'(LANE) < i_active_sources) && (pkt != '0);

    assign o_entry.src = stm_pkg::SRC_W'(LANE);
    assign o_entry.pkt = pkt;

endmodule

>>> rtl/stm_merge.sv
// stm_merge: compacts the qualified lanes in source order and books the slot
// against the logical queue occupancy. Depends on stm_pkg.
module stm_merge #(
    parameter int NUM_SOURCES = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_RATE    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [NUM_SOURCES-1:0]    i_valid,
    input  stm_pkg::t_entry           i_entry [NUM_SOURCES],
    input  logic [stm_pkg::CFG_W-1:0] i_output_rate,
    output stm_pkg::t_entry           o_list  [NUM_SOURCES],
    output stm_pkg::t_slot_job        o_job
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(NUM_SOURCES);

    logic [CW-1:0]             r_lcount;
    logic                      r_drop;
    logic [CW-1:0]             n_lcount;
    logic                      n_drop;

    logic [stm_pkg::CNT_W-1:0] nvalid;
    logic [CW-1:0]             space;
    logic [stm_pkg::CNT_W-1:0] kept;
    logic [CW-1:0]             filled;
    logic [stm_pkg::CFG_W-1:0] rate;
    logic [stm_pkg::CNT_W-1:0] pops;

    // Compaction: valid lanes packed to the front in ascending source order
    always_comb begin
        logic [stm_pkg::CNT_W-1:0] cnt;
        cnt = '0;
        for (int s = 0; s < NUM_SOURCES; s++) begin
            o_list[s] = '0;
        end
        for (int s = 0; s < NUM_SOURCES; s++) begin
            if (i_valid[s]) begin
                o_list[cnt[IW-1:0]] = i_entry[s];
                cnt = cnt + 1'b1;
            end
        end
        nvalid = cnt;
    end

    // Arrivals beyond the free space are dropped
    assign space  = CW'(QUEUE_DEPTH) - r_lcount;
    assign kept   = (CW'(nvalid) < space) ? nvalid : stm_pkg::CNT_W'(space);
    assign n_drop = r_drop | (CW'(nvalid) > space);
    assign filled = r_lcount + CW'(kept);

    // Departures limited by the saturated rate and by what is queued
    assign rate     = (i_output_rate > stm_pkg::CFG_W'(MAX_RATE))
                      ? stm_pkg::CFG_W'(MAX_RATE) : i_output_rate;
    assign pops     = (CW'(rate) < filled) ? stm_pkg::CNT_W'(rate)
                                           : stm_pkg::CNT_W'(filled);
    assign n_lcount = filled - CW'(pops);

    assign o_job.n_arr = kept;
    assign o_job.n_pop = pops;
    assign o_job.ovf   = n_drop;

    // Logical occupancy and sticky drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcount <= '0;
            r_drop   <= 1'b0;
        end else if (i_load) begin
            r_lcount <= n_lcount;
            r_drop   <= n_drop;
        end
    end

endmodule

>>> rtl/stm_queue.sv
// stm_queue: shared packet FIFO memory with an arrival writer, a departure
// reader and a two-entry output buffer. Depends on stm_pkg and stm_if.
module stm_queue #(
    parameter int NUM_SOURCES = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  stm_pkg::t_entry    i_list [NUM_SOURCES],
    input  stm_pkg::t_slot_job i_job,
    output logic               o_load_ready,
    stm_out_if.source          o_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(stm_pkg::t_entry);

    logic [EW-1:0]             r_mem [QUEUE_DEPTH];
    logic [AW-1:0]             r_wptr;
    logic [AW-1:0]             r_rptr;
    logic [CW-1:0]             r_pcount;

    stm_pkg::t_entry           r_wr_list [NUM_SOURCES];
    logic [stm_pkg::CNT_W-1:0] r_wr_left;
    logic [stm_pkg::CNT_W-1:0] r_rd_left;
    logic                      r_rd_ovf;

    logic                      r_inflight;
    stm_pkg::t_entry           r_rd_entry;
    logic                      r_if_last;
    logic                      r_if_ovf;

    stm_pkg::t_out_item        r_ob [2];
    logic [1:0]                r_ob_cnt;

    logic                      wr_fire;
    logic                      rd_fire;
    logic                      wr_free;
    logic                      rd_free;
    logic                      pop;
    logic [2:0]                occ_next;
    logic                      push_idx;
    stm_pkg::t_out_item        rd_item;

    // Writer: one arrival per cycle while there is physical room
    assign wr_fire = (r_wr_left != '0) && (r_pcount != CW'(QUEUE_DEPTH));
    assign wr_free = (r_wr_left == '0) || ((r_wr_left == 4'd1) && wr_fire);

    // Reader: one departure per cycle while data is written and buffer has room
    assign pop      = o_out.valid && o_out.ready;
    assign occ_next = 3'(r_ob_cnt) + 3'(r_inflight) - 3'(pop);
    assign rd_fire  = (r_rd_left != '0) && (r_pcount != '0) && (occ_next < 3'd2);
    assign rd_free  = (r_rd_left == '0) || ((r_rd_left == 4'd1) && rd_fire);

    assign o_load_ready = wr_free && rd_free;

    // Slot jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_left <= '0;
            r_rd_left <= '0;
            r_rd_ovf  <= 1'b0;
        end else begin
            if (i_load) begin
                r_wr_left <= i_job.n_arr;
            end else if (wr_fire) begin
                r_wr_left <= r_wr_left - 1'b1;
            end
            if (i_load) begin
                r_rd_left <= i_job.n_pop;
                r_rd_ovf  <= i_job.ovf;
            end else if (rd_fire) begin
                r_rd_left <= r_rd_left - 1'b1;
            end
        end
    end

    // Arrival list shifts down as entries are written
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_wr_list <= i_list;
        end else if (wr_fire) begin
            for (int i = 0; i < NUM_SOURCES - 1; i++) begin
                r_wr_list[i] <= r_wr_list[i + 1];
            end
        end
    end

    // Pointers and physical occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_pcount <= '0;
        end else begin
            if (wr_fire) begin
                r_wptr <= (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_fire) begin
                r_rptr <= (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_pcount <= r_pcount + CW'(wr_fire) - CW'(rd_fire);
        end
    end

    // Queue memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wptr] <= r_wr_list[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_fire) begin
            r_rd_entry <= r_mem[r_rptr];
            r_if_last  <= (r_rd_left == 4'd1);
            r_if_ovf   <= r_rd_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
        end else begin
            r_inflight <= rd_fire;
        end
    end

    // Output buffer: new data lands in the first free slot after any shift
    assign push_idx = r_ob_cnt[0] ^ pop;
    assign rd_item  = '{entry: r_rd_entry, last: r_if_last, ovf: r_if_ovf};

    always_ff @(posedge i_clk) begin
        if (r_inflight && !push_idx) begin
            r_ob[0] <= rd_item;
        end else if (pop) begin
            r_ob[0] <= r_ob[1];
        end
        if (r_inflight && push_idx) begin
            r_ob[1] <= rd_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else begin
            r_ob_cnt <= r_ob_cnt + 2'(r_inflight) - 2'(pop);
        end
    end

    assign o_out.valid          = (r_ob_cnt != '0);
    assign o_out.source_address = r_ob[0].entry.src;
    assign o_out.packet_number  = r_ob[0].entry.pkt;
    assign o_out.last_of_slot   = r_ob[0].last;
    assign o_out.overflow_seen  = r_ob[0].ovf;

    // Checks
    a_pcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_ob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= 2'd2)
        else $error("output buffer overrun");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with unequal pointers");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_ob_cnt == 2'd2) && !pop) |-> !r_inflight)
        else $error("read data arriving at a full output buffer");

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for statistical_tdm_multiplexer.
// Drives random and directed slot requests, mirrors the shared queue, checks each departure.
// Depends on stm_pkg, stm_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_SOURCES    = 8;
    localparam int QUEUE_DEPTH    = 64;
    localparam int MAX_RATE       = 8;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Slot request side
    logic                       slot_valid = 1'b0;
    logic [stm_pkg::SLOT_W-1:0] slot_word  = '0;
    logic                       slot_taken = 1'b0;
    int                         gap_left   = 0;

    // Departure side
    logic take_ready = 1'b0;
    int   stall_left = 0;

    // Register port
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [stm_pkg::APB_AW-1:0] paddr   = '0;
    logic [stm_pkg::APB_DW-1:0] pwdata  = '0;
    logic [stm_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    // Mirror of the block state and its registers
    logic [stm_pkg::CFG_W-1:0] cfg_rate    = stm_pkg::OUTPUT_RATE_RST;
    logic [stm_pkg::CFG_W-1:0] cfg_sources = stm_pkg::ACTIVE_SOURCES_RST;
    stm_pkg::t_entry           queue_mirror[$];
    logic                      drop_seen = 1'b0;

    logic [stm_pkg::SLOT_W-1:0] pending_slots[$];
    stm_pkg::t_out_item         due_departures[$];
    int                         mismatches   = 0;
    int                         quiet_cycles = 0;
    bit                         steady       = 1'b1;

    stm_in_if  slot_if();
    stm_out_if pkt_if();

    assign slot_if.valid        = slot_valid;
    assign slot_if.slot_packets = slot_word;
    assign pkt_if.ready         = take_ready;

    statistical_tdm_multiplexer #(
        .NUM_SOURCES(NUM_SOURCES),
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_RATE   (MAX_RATE)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (slot_if),
        .o_out  (pkt_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #10 i_clk = ~i_clk;

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Append one slot word to the driver's list
    function automatic void add_slot(input logic [stm_pkg::SLOT_W-1:0] word);
        pending_slots = {pending_slots, word};
    endfunction

    // One time slot: enqueue arrivals in source order, then drain up to the rate
    function automatic void mux_slot(input logic [stm_pkg::SLOT_W-1:0] lanes);
        int                 nsrc;
        int                 rate;
        int                 sent;
        int                 s;
        logic [3:0]         pkt;
        stm_pkg::t_entry    arrival;
        stm_pkg::t_out_item dep;
        nsrc = (cfg_sources > NUM_SOURCES) ? NUM_SOURCES : int'(cfg_sources);
        rate = (cfg_rate > MAX_RATE) ? MAX_RATE : int'(cfg_rate);
        for (s = 0; s < nsrc; s++) begin
            pkt = lanes[4*s +: 4];
            if (pkt != 4'd0) begin
                if (queue_mirror.size() >= QUEUE_DEPTH) begin
                    drop_seen = 1'b1;
                end else begin
                    arrival.src = s[2:0];
                    arrival.pkt = pkt;
                    queue_mirror = {queue_mirror, arrival};
                end
            end
        end
        sent = 0;
        while (sent < rate && queue_mirror.size() > 0) begin
            dep.entry = queue_mirror.pop_front();
            dep.ovf   = drop_seen;
            sent++;
            dep.last  = (sent == rate || queue_mirror.size() == 0);
            due_departures = {due_departures, dep};
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Request driver: new slot word at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (slot_valid && !slot_taken) begin
            // hold the request
        end else if (gap_left > 0) begin
            gap_left--;
            slot_valid <= 1'b0;
        end else if (pending_slots.size() != 0) begin
            slot_valid <= 1'b1;
            slot_word  <= pending_slots.pop_front();
            gap_left = pick_gap();
        end else begin
            slot_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            take_ready <= 1'b0;
        end else begin
            take_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Input monitor: predict departures for each accepted slot
    always @(posedge i_clk) begin
        slot_taken <= slot_if.valid && slot_if.ready;
        if (i_rst_n && slot_if.valid && slot_if.ready)
            mux_slot(slot_if.slot_packets);
    end

    // Output monitor: compare each departure with the oldest prediction
    always @(posedge i_clk) begin
        stm_pkg::t_out_item want;
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            if (due_departures.size() == 0) begin
                $display("%0t: unexpected departure, expected none, actual src=%0d pkt=%0d",
                         $time, pkt_if.source_address, pkt_if.packet_number);
                mismatches++;
            end else begin
                want = due_departures.pop_front();
                check_field("source_address", int'(want.entry.src),
                            int'(pkt_if.source_address));
                check_field("packet_number", int'(want.entry.pkt),
                            int'(pkt_if.packet_number));
                check_field("last_of_slot", int'(want.last), int'(pkt_if.last_of_slot));
                check_field("overflow_seen", int'(want.ovf), int'(pkt_if.overflow_seen));
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n || (slot_if.valid && slot_if.ready) || (pkt_if.valid && pkt_if.ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until everything queued went out and every departure arrived
    task automatic wait_quiet();
        while (pending_slots.size() != 0 || slot_valid || due_departures.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle; upper data bits are don't-care
    task automatic write_reg(input logic [0:0] reg_sel, input logic [3:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == stm_pkg::REG_OUTPUT_RATE)
            cfg_rate = value;
        else
            cfg_sources = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] rate, input logic [3:0] srcs);
        write_reg(stm_pkg::REG_OUTPUT_RATE, rate);
        write_reg(stm_pkg::REG_ACTIVE_SOURCES, srcs);
    endtask

    // Random slots; idle_pct is the chance per lane of an idle source
    task automatic run_phase(input logic [3:0] rate, input logic [3:0] srcs, input int count,
                             input int idle_pct, input bit no_gaps);
        logic [stm_pkg::SLOT_W-1:0] word;
        int                         n;
        int                         s;
        set_config(rate, srcs);
        steady = no_gaps;
        for (n = 0; n < count; n++) begin
            for (s = 0; s < NUM_SOURCES; s++)
                word[4*s +: 4] = ($urandom_range(0, 99) < idle_pct) ? 4'd0
                                                                    : 4'($urandom_range(1, 15));
            add_slot(word);
        end
        wait_quiet();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: rate 1, all sources
        steady = 1'b1;
        add_slot(32'h0000_0000);
        add_slot(32'h0000_0003);
        add_slot(32'h0000_0021);
        wait_quiet();

        // Full rate: lane extremes, alternating bits, idle slot
        set_config(4'd8, 4'd8);
        steady = 1'b0;
        add_slot(32'hFFFF_FFFF);
        add_slot(32'h0000_0000);
        add_slot(32'hA5A5_A5A5);
        add_slot(32'h5A5A_5A5A);
        add_slot(32'hF000_0001);
        add_slot(32'h0F0F_0F0F);
        wait_quiet();

        // Rate and source count above their limits saturate
        set_config(4'd15, 4'd15);
        add_slot(32'hFFFF_FFFF);
        add_slot(32'h1234_5678);
        wait_quiet();

        // Lowest nonzero settings, then an idle slot
        set_config(4'd1, 4'd1);
        add_slot(32'hFFFF_FFFF);
        add_slot(32'h8765_432E);
        add_slot(32'h0000_0000);
        wait_quiet();

        // Random traffic before any drop
        run_phase(4'd8, 4'd8, 15, 50, 1'b0);
        run_phase(4'd1, 4'd1, 12, 30, 1'b1);
        run_phase(4'd3, 4'd5, 15, 60, 1'b0);
        run_phase(4'd2, 4'd8, 12, 80, 1'b0);
        run_phase(4'd12, 4'd3, 12, 20, 1'b0);
        run_phase(4'd5, 4'd11, 12, 50, 1'b1);

        // Zero rate: queue fills up and drops arrivals from later sources
        run_phase(4'd0, 4'd8, 10, 0, 1'b0);
        // Zero sources: lanes ignored, backlog drains with the flag set
        run_phase(4'd8, 4'd0, 10, 30, 1'b0);

        run_phase(4'd4, 4'd8, 15, 50, 1'b0);
        run_phase(4'd7, 4'd6, 12, 100, 1'b0);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
